// ===== rtl/ltcbd_pkg.sv =====
// ============================================================================
// ltcbd_pkg
// Shared types and constants of the biphase-mark timecode edge decoder.
// ============================================================================
`default_nettype none

package ltcbd_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Frame register geometry: ten bytes, byte 0 most significant.
	localparam int FRAME_BYTES = 10;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;

	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [CFG_DATA_W-1:0] cfg_word_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 3'd4;

	// Configuration reset values.
	localparam cfg_word_t SHORT_MIN_RST = 16'd166;
	localparam cfg_word_t SHORT_MAX_RST = 16'd332;
	localparam cfg_word_t LONG_MIN_RST  = 16'd333;
	localparam cfg_word_t LONG_MAX_RST  = 16'd498;
	localparam cfg_word_t SYNC_WORD_RST = 16'hBFFC;

	// Edge classification codes as reported on the result channel.
	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_HALF = 2'd1,
		CLS_ONE  = 2'd2,
		CLS_ZERO = 2'd3
	} edge_class_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		cfg_word_t short_min;
		cfg_word_t short_max;
		cfg_word_t long_min;
		cfg_word_t long_max;
		cfg_word_t sync_word;
	} cfg_t;

	// Decision for one edge, handed from the classifier to the frame register.
	typedef struct packed {
		edge_class_t cls;
		logic        shift_en;
		logic        shift_bit;
		logic        half_next;
	} decision_t;

endpackage

`default_nettype wire

// ===== rtl/ltcbd_edge_if.sv =====
// ============================================================================
// ltcbd_edge_if
// Edge timestamp channel: valid/ready handshake carrying one timestamp word.
// ============================================================================
`default_nettype none

interface ltcbd_edge_if #(
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] edge_time;

	modport source (output valid, output edge_time, input ready);
	modport sink   (input valid, input edge_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/ltcbd_result_if.sv =====
// ============================================================================
// ltcbd_result_if
// Result channel: sync flag, edge class and the eight payload bytes.
// ============================================================================
`default_nettype none

interface ltcbd_result_if;
	logic       valid;
	logic       ready;
	logic       sync_found;
	logic [1:0] edge_class;
	logic [7:0] byte_two;
	logic [7:0] byte_three;
	logic [7:0] byte_four;
	logic [7:0] byte_five;
	logic [7:0] byte_six;
	logic [7:0] byte_seven;
	logic [7:0] byte_eight;
	logic [7:0] byte_nine;

	modport source (
		output valid, output sync_found, output edge_class,
		output byte_two, output byte_three, output byte_four, output byte_five,
		output byte_six, output byte_seven, output byte_eight, output byte_nine,
		input ready
	);
	modport sink (
		input valid, input sync_found, input edge_class,
		input byte_two, input byte_three, input byte_four, input byte_five,
		input byte_six, input byte_seven, input byte_eight, input byte_nine,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/ltcbd_cfg_if.sv =====
// ============================================================================
// ltcbd_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface ltcbd_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ltcbd_pkg::CFG_IDX_W-1:0]     index;
	logic [ltcbd_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ltcbd_cfg_regs.sv =====
// ============================================================================
// ltcbd_cfg_regs
// Window and sync word registers, written through the configuration channel.
// ============================================================================
`default_nettype none

module ltcbd_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ltcbd_cfg_if.sink          cfg,
	output ltcbd_pkg::cfg_t    cfg_q
);

	// Writes are taken whenever offered, so the channel is always ready.
	assign cfg.ready = 1'b1;

	// Register file; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min <= ltcbd_pkg::SHORT_MIN_RST;
			cfg_q.short_max <= ltcbd_pkg::SHORT_MAX_RST;
			cfg_q.long_min  <= ltcbd_pkg::LONG_MIN_RST;
			cfg_q.long_max  <= ltcbd_pkg::LONG_MAX_RST;
			cfg_q.sync_word <= ltcbd_pkg::SYNC_WORD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ltcbd_pkg::REG_SHORT_MIN: cfg_q.short_min <= cfg.data;
				ltcbd_pkg::REG_SHORT_MAX: cfg_q.short_max <= cfg.data;
				ltcbd_pkg::REG_LONG_MIN:  cfg_q.long_min  <= cfg.data;
				ltcbd_pkg::REG_LONG_MAX:  cfg_q.long_max  <= cfg.data;
				ltcbd_pkg::REG_SYNC_WORD: cfg_q.sync_word <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ltcbd_classify.sv =====
// ============================================================================
// ltcbd_classify
// Measures the interval since the previous edge and classifies it against
// the short and long windows.
// ============================================================================
`default_nettype none

module ltcbd_classify #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic [TIME_WIDTH-1:0] now_time,
	input  wire logic [TIME_WIDTH-1:0] last_time,
	input  wire logic                  half_seen,
	input  wire ltcbd_pkg::cfg_t       cfg_q,
	output ltcbd_pkg::decision_t       decision
);

	logic [TIME_WIDTH-1:0] delta;
	logic                  in_short;
	logic                  in_long;

	// Interval modulo the timer width.
	assign delta = now_time - last_time;

	// Strict window tests; the short window takes priority.
	assign in_short = (delta < TIME_WIDTH'(cfg_q.short_max)) &&
	                  (delta > TIME_WIDTH'(cfg_q.short_min));
	assign in_long  = (delta < TIME_WIDTH'(cfg_q.long_max)) &&
	                  (delta > TIME_WIDTH'(cfg_q.long_min));

	// Decide the class, the bit to shift and the next half-edge flag.
	always_comb begin
		decision.cls       = ltcbd_pkg::CLS_NONE;
		decision.shift_en  = 1'b0;
		decision.shift_bit = 1'b0;
		decision.half_next = half_seen;
		if (in_short) begin
			if (half_seen) begin
				decision.cls       = ltcbd_pkg::CLS_ONE;
				decision.shift_en  = 1'b1;
				decision.shift_bit = 1'b1;
				decision.half_next = 1'b0;
			end else begin
				decision.cls       = ltcbd_pkg::CLS_HALF;
				decision.half_next = 1'b1;
			end
		end else if (in_long) begin
			decision.cls      = ltcbd_pkg::CLS_ZERO;
			decision.shift_en = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ltcbd_frame.sv =====
// ============================================================================
// ltcbd_frame
// 80-bit frame shift register and half-edge flag.
// ============================================================================
`default_nettype none

module ltcbd_frame (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire ltcbd_pkg::decision_t decision,
	output ltcbd_pkg::frame_t         frame_next,
	output logic                      half_q
);

	ltcbd_pkg::frame_t frame_q;

	// New bits enter at the top of byte 0 and move toward byte 9.
	assign frame_next = decision.shift_en ?
	                    {decision.shift_bit, frame_q[ltcbd_pkg::FRAME_BITS-1:1]} :
	                    frame_q;

	// State moves forward once per edge as it leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			half_q  <= 1'b0;
		end else if (advance) begin
			frame_q <= frame_next;
			half_q  <= decision.half_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ltc_biphase_edge_decoder.sv =====
// Path: an accepted edge word is registered in the input stage; classify, shift
// and sync compare then run as a single pass into the result register.
// Throughput: one edge per cycle while the consumer takes results. While the
// result register waits, the input stage takes one more edge, then holds off.
// Reset: arst_n clears the frame register, half-edge flag, last timestamp and
// pipeline valids, and loads the window and sync word registers with defaults.
// ============================================================================
// ltc_biphase_edge_decoder
// Biphase-mark timecode edge decoder: classifies edge intervals, assembles
// the 80-bit frame and flags the sync word.
// ============================================================================
`default_nettype none

module ltc_biphase_edge_decoder #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ltcbd_edge_if.sink     edges,
	ltcbd_result_if.source results,
	ltcbd_cfg_if.sink      cfg
);

	ltcbd_pkg::cfg_t       cfg_q;
	ltcbd_pkg::decision_t  decision;
	ltcbd_pkg::frame_t     frame_next;
	logic                  half_q;

	logic                  valid_s1;
	logic [TIME_WIDTH-1:0] time_s1;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic                  advance;
	logic                  res_valid_q;
	logic                  sync_hit;

	// Configuration registers.
	ltcbd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// Item moves from the input stage to the result register when the
	// result register is empty or being drained.
	assign advance     = valid_s1 && (!res_valid_q || results.ready);
	assign edges.ready = !valid_s1 || advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edges.ready) begin
			valid_s1 <= edges.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edges.valid && edges.ready) begin
			time_s1 <= edges.edge_time;
		end
	end

	// Timestamp of the previous edge; the first edge is measured from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
		end else if (advance) begin
			last_time_q <= time_s1;
		end
	end

	// Interval classification.
	ltcbd_classify #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_classify (
		.now_time  (time_s1),
		.last_time (last_time_q),
		.half_seen (half_q),
		.cfg_q     (cfg_q),
		.decision  (decision)
	);

	// Frame shift register and half-edge flag.
	ltcbd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.decision   (decision),
		.frame_next (frame_next),
		.half_q     (half_q)
	);

	// Sync word sits in bytes 0 and 1 of the updated frame.
	assign sync_hit = (frame_next[ltcbd_pkg::FRAME_BITS-1 -: 16] == cfg_q.sync_word);

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			results.sync_found <= sync_hit;
			results.edge_class <= decision.cls;
			results.byte_two   <= frame_next[63:56];
			results.byte_three <= frame_next[55:48];
			results.byte_four  <= frame_next[47:40];
			results.byte_five  <= frame_next[39:32];
			results.byte_six   <= frame_next[31:24];
			results.byte_seven <= frame_next[23:16];
			results.byte_eight <= frame_next[15:8];
			results.byte_nine  <= frame_next[7:0];
		end
	end

	assign results.valid = res_valid_q;

endmodule

`default_nettype wire

// ===== rtl/ltcbd_checker.sv =====
// ============================================================================
// ltcbd_port_checks
// Port-level checks of the decoder: result handshake and the consistency of
// successive results with the shift and half-edge rules.
// ============================================================================
`default_nettype none

module ltcbd_port_checks (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       sync_found,
	input wire logic [1:0] edge_class,
	input wire logic [63:0] bytes
);

	logic        res_acc;
	logic        half_q;
	logic        have_prev_q;
	logic [63:0] prev_q;

	assign res_acc = res_valid && res_ready;

	// Track the half-edge flag and the last delivered payload from the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
		end else if (res_acc) begin
			have_prev_q <= 1'b1;
			prev_q      <= bytes;
			if (edge_class == ltcbd_pkg::CLS_HALF) begin
				half_q <= 1'b1;
			end else if (edge_class == ltcbd_pkg::CLS_ONE) begin
				half_q <= 1'b0;
			end
		end
	end

	// A stalled result holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(bytes) &&
		$stable(edge_class) && $stable(sync_found))
		else $error("result changed while stalled");

	// A first half edge only appears when no half edge is pending.
	a_half_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && (edge_class == ltcbd_pkg::CLS_HALF) |-> !half_q)
		else $error("second half edge reported as first half");

	// A one is only shifted after a pending half edge.
	a_one_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && (edge_class == ltcbd_pkg::CLS_ONE) |-> half_q)
		else $error("one shifted without a pending half edge");

	// Without a shift the payload bytes do not move.
	a_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && have_prev_q &&
		(edge_class == ltcbd_pkg::CLS_NONE || edge_class == ltcbd_pkg::CLS_HALF)
		|-> bytes == prev_q)
		else $error("payload changed without a shift");

	// A shift moves the payload down by exactly one bit.
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && have_prev_q &&
		(edge_class == ltcbd_pkg::CLS_ONE || edge_class == ltcbd_pkg::CLS_ZERO)
		|-> bytes[62:0] == prev_q[63:1])
		else $error("payload not shifted by one bit");

endmodule

bind ltc_biphase_edge_decoder ltcbd_port_checks u_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.sync_found (results.sync_found),
	.edge_class (results.edge_class),
	.bytes      ({results.byte_two, results.byte_three, results.byte_four,
	              results.byte_five, results.byte_six, results.byte_seven,
	              results.byte_eight, results.byte_nine})
);

`default_nettype wire
